// File: rtl/bap_pkg.sv
// Shared types and constants for the 2x2 box-average pixelation block.
// Used by block_average_pixelate_2x2 and its port checker. No dependencies.
package bap_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 9;
	localparam int COORD_W = 10;
	localparam int SIZE_W = 10;
	localparam int CFG_IDX_W = 2;
	localparam int BEAT_W = 2;

	localparam logic [SIZE_W-1:0] ACROSS_RESET = 10'd160;
	localparam logic [SIZE_W-1:0] DOWN_RESET = 10'd120;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCKS_ACROSS = 2'd0,
		CFG_BLOCKS_DOWN = 2'd1
	} cfg_reg_t;

	localparam logic [BEAT_W-1:0] BEAT_TL = 2'd0;
	localparam logic [BEAT_W-1:0] BEAT_BR = 2'd1;
	localparam logic [BEAT_W-1:0] BEAT_TR = 2'd2;
	localparam logic [BEAT_W-1:0] BEAT_BL = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] row_base;
		logic [COORD_W-1:0] col_base;
		logic frame_end;
	} blk_pos_t;

endpackage

// File: rtl/block_average_pixelate_2x2.sv
// Top level of the 2x2 box-average pixelation block.
// Depends on bap_pkg and bap_ram.
//
//   Channel  Handshake                  Payload
//   pixel    pixel_valid / pixel_stall   pixel
//   result   result_valid / result_stall out_row, out_col, value, block_last, frame_last
//   config   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// Pixels of even rows and left pixels of odd rows are taken one per cycle.
// A pixel that completes a block reads the line RAM; the pair sum and the RAM read
// are registered in stage s1, the average in stage s2, and the output register then
// takes it; its four results leave one per cycle while result_stall is low.
// Reset clears positions and pipeline valids and loads the default sizes; the line
// RAM is not cleared.
// A completing pixel waits while an earlier block sits in the pipeline, so a
// stalled result port soon stalls the pixel channel.
module block_average_pixelate_2x2 #(
	parameter int MAX_BLOCKS_ACROSS = 512,
	parameter int MAX_BLOCKS_DOWN = 512
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pixel_valid,
	output logic pixel_stall,
	input  logic [bap_pkg::PIX_W-1:0] pixel,
	output logic result_valid,
	input  logic result_stall,
	output logic [bap_pkg::COORD_W-1:0] out_row,
	output logic [bap_pkg::COORD_W-1:0] out_col,
	output logic [bap_pkg::PIX_W-1:0] value,
	output logic block_last,
	output logic frame_last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [bap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bap_pkg::SIZE_W-1:0] cfg_data
);
	import bap_pkg::*;

	localparam int SLOT_W = (MAX_BLOCKS_ACROSS > 1) ? $clog2(MAX_BLOCKS_ACROSS) : 1;
	localparam int RP_W = (MAX_BLOCKS_DOWN > 1) ? $clog2(MAX_BLOCKS_DOWN) : 1;

	logic [SIZE_W-1:0] blocks_across_q, blocks_down_q;
	logic [SLOT_W-1:0] last_slot;
	logic [RP_W-1:0] last_rowpair;

	logic [SLOT_W-1:0] slot_q;
	logic phase_q;
	logic [RP_W-1:0] rowpair_q;
	logic rowodd_q;
	logic [PIX_W-1:0] held_q;

	logic pix_xfer, cfg_hit, completes, pair_sum_en;
	logic [SUM_W-1:0] pair_sum;
	logic [SUM_W-1:0] ram_rdata;

	logic v_s1, v_s2;
	logic [SUM_W-1:0] sum_s1;
	blk_pos_t pos_s1, pos_s2;
	logic [PIX_W-1:0] avg_s2;
	logic [SUM_W:0] total_s1;

	logic v_q;
	logic [BEAT_W-1:0] beat_q;
	blk_pos_t pos_q;
	logic [PIX_W-1:0] avg_q;
	logic emit_done, load_emit;

	always_comb begin
		if (blocks_across_q == '0) begin
			last_slot = '0;
		end else if ({22'd0, blocks_across_q} > MAX_BLOCKS_ACROSS) begin
			last_slot = SLOT_W'(MAX_BLOCKS_ACROSS - 1);
		end else begin
			last_slot = SLOT_W'(blocks_across_q - 10'd1);
		end
		if (blocks_down_q == '0) begin
			last_rowpair = '0;
		end else if ({22'd0, blocks_down_q} > MAX_BLOCKS_DOWN) begin
			last_rowpair = RP_W'(MAX_BLOCKS_DOWN - 1);
		end else begin
			last_rowpair = RP_W'(blocks_down_q - 10'd1);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit = cfg_valid && (cfg_index == CFG_BLOCKS_ACROSS || cfg_index == CFG_BLOCKS_DOWN);

	assign completes = phase_q && rowodd_q;
	assign pixel_stall = completes && (v_s1 || v_s2);
	assign pix_xfer = pixel_valid && !pixel_stall;
	assign pair_sum_en = pix_xfer && phase_q;
	assign pair_sum = SUM_W'(held_q) + SUM_W'(pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_across_q <= ACROSS_RESET;
			blocks_down_q <= DOWN_RESET;
			slot_q <= '0;
			phase_q <= 1'b0;
			rowpair_q <= '0;
			rowodd_q <= 1'b0;
			held_q <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == CFG_BLOCKS_ACROSS) begin
				blocks_across_q <= cfg_data;
			end else begin
				blocks_down_q <= cfg_data;
			end
			slot_q <= '0;
			phase_q <= 1'b0;
			rowpair_q <= '0;
			rowodd_q <= 1'b0;
		end else if (pix_xfer) begin
			if (!phase_q) begin
				held_q <= pixel;
				phase_q <= 1'b1;
			end else begin
				phase_q <= 1'b0;
				if (slot_q == last_slot) begin
					slot_q <= '0;
					rowodd_q <= !rowodd_q;
					if (rowodd_q) begin
						rowpair_q <= (rowpair_q == last_rowpair) ? '0 : rowpair_q + 1'b1;
					end
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
		end
	end

	bap_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_BLOCKS_ACROSS)
	) u_line_ram (
		.clk(clk),
		.we(pair_sum_en && !rowodd_q),
		.waddr(slot_q),
		.wdata(pair_sum),
		.re(pair_sum_en && rowodd_q),
		.raddr(slot_q),
		.rdata(ram_rdata)
	);

	assign total_s1 = {1'b0, ram_rdata} + {1'b0, sum_s1};
	assign emit_done = v_q && !result_stall && beat_q == BEAT_BL;
	assign load_emit = v_s2 && (!v_q || emit_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q <= 1'b0;
			beat_q <= BEAT_TL;
		end else begin
			v_s1 <= pix_xfer && completes && !cfg_hit;
			if (v_s1) begin
				v_s2 <= 1'b1;
			end else if (load_emit) begin
				v_s2 <= 1'b0;
			end
			if (load_emit) begin
				v_q <= 1'b1;
				beat_q <= BEAT_TL;
			end else if (emit_done) begin
				v_q <= 1'b0;
			end else if (v_q && !result_stall) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_xfer && completes) begin
			sum_s1 <= pair_sum;
			pos_s1.row_base <= COORD_W'({rowpair_q, 1'b0});
			pos_s1.col_base <= COORD_W'({slot_q, 1'b0});
			pos_s1.frame_end <= (rowpair_q == last_rowpair) && (slot_q == last_slot);
		end
		if (v_s1) begin
			pos_s2 <= pos_s1;
			avg_s2 <= total_s1[SUM_W:2];
		end
		if (load_emit) begin
			pos_q <= pos_s2;
			avg_q <= avg_s2;
		end
	end

	assign result_valid = v_q;
	assign value = avg_q;
	assign block_last = (beat_q == BEAT_BL);
	assign frame_last = (beat_q == BEAT_BL) && pos_q.frame_end;

	always_comb begin
		case (beat_q)
			BEAT_TL: begin
				out_row = pos_q.row_base;
				out_col = pos_q.col_base;
			end
			BEAT_BR: begin
				out_row = pos_q.row_base | COORD_W'(1);
				out_col = pos_q.col_base | COORD_W'(1);
			end
			BEAT_TR: begin
				out_row = pos_q.row_base;
				out_col = pos_q.col_base | COORD_W'(1);
			end
			default: begin
				out_row = pos_q.row_base | COORD_W'(1);
				out_col = pos_q.col_base;
			end
		endcase
	end

endmodule

// File: rtl/bap_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
module bap_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/bap_checker.sv
// Port-level checker for block_average_pixelate_2x2, attached by a bind below.
// Depends on bap_pkg.
module bap_port_checker (
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_stall,
	input logic [bap_pkg::COORD_W-1:0] out_row,
	input logic [bap_pkg::COORD_W-1:0] out_col,
	input logic [bap_pkg::PIX_W-1:0] value,
	input logic block_last,
	input logic frame_last
);
	import bap_pkg::*;

	// The frame ends only on the closing result of a block.
	a_frame_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_last |-> block_last)
		else $error("frame_last without block_last");

	// The four results of a block leave without gaps.
	a_block_runs: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !block_last |=> result_valid)
		else $error("result run broken inside a block");

	// Within a block every result carries the same average.
	a_same_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !block_last |=> $stable(value))
		else $error("average changed inside a block");

	// The closing result of a block is its bottom-left pixel.
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && block_last |-> out_row[0] && !out_col[0])
		else $error("block_last on wrong pixel of the block");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_row)
		&& $stable(out_col))
		else $error("stalled result changed");

endmodule

bind block_average_pixelate_2x2 bap_port_checker u_bap_checker (
	.clk(clk),
	.arst_n(arst_n),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.out_row(out_row),
	.out_col(out_col),
	.value(value),
	.block_last(block_last),
	.frame_last(frame_last)
);
